>>> src/upf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upf_pkg: shared types and constants of the proxy udp frame parser
// byte classes, status codes, address kinds, register map, result layout
// ----------------------------------------------------------------------------
package upf_pkg;

   // csr map: four 32-bit registers at byte addresses 4*i
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_MAGIC       = 2'd0,
      REG_IPV4_CODE   = 2'd1,
      REG_DOMAIN_CODE = 2'd2,
      REG_IPV6_CODE   = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      CLS_HEADER  = 2'd0,
      CLS_ADDRESS = 2'd1,
      CLS_PAYLOAD = 2'd2,
      CLS_DISCARD = 2'd3
   } class_type;

   typedef enum logic [2:0] {
      ST_BUSY       = 3'd0,
      ST_OK         = 3'd1,
      ST_BAD_MAGIC  = 3'd2,
      ST_BAD_LENGTH = 3'd3,
      ST_BAD_TYPE   = 3'd4,
      ST_OVERRUN    = 3'd5,
      ST_TRUNCATED  = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      KIND_IPV4   = 2'd0,
      KIND_DOMAIN = 2'd1,
      KIND_IPV6   = 2'd2
   } kind_type;

   localparam logic [15:0] IPV4_ADDR_BYTES = 16'd4;
   localparam logic [15:0] IPV6_ADDR_BYTES = 16'd16;
   localparam logic [15:0] PORT_BYTES      = 16'd2;

   typedef struct packed {
      logic [15:0] magic;
      logic [7:0]  ipv4_code;
      logic [7:0]  domain_code;
      logic [7:0]  ipv6_code;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  domain_length;
      logic [15:0] frame_length;
      logic [15:0] port_number;
      kind_type    address_kind;
      status_type  status;
      logic        frame_done;
      class_type   byte_class;
      logic [7:0]  byte_out;
   } result_type;

endpackage

>>> src/upf_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upf_parser: front end of the frame parser
// walks the frame layout one byte per transaction and builds the tagged result
// ----------------------------------------------------------------------------
module upf_parser #(
   parameter int HEADER_BYTES = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  upf_pkg::cfg_type    cfg,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                end_of_data,
   output upf_pkg::result_type result
);

   typedef enum logic [3:0] {
      PH_MAGIC_HI = 4'd0,
      PH_MAGIC_LO = 4'd1,
      PH_LEN_HI   = 4'd2,
      PH_LEN_LO   = 4'd3,
      PH_HDR_REST = 4'd4,
      PH_TYPE     = 4'd5,
      PH_DLEN     = 4'd6,
      PH_ADDR     = 4'd7,
      PH_PORT_HI  = 4'd8,
      PH_PORT_LO  = 4'd9,
      PH_PAYLOAD  = 4'd10
   } phase_type;

   localparam logic [15:0] HDR_LEN    = 16'(HEADER_BYTES);
   localparam logic [15:0] MIN_LENGTH = 16'(HEADER_BYTES + 1);

   phase_type         phase_ff, phase_in;
   logic [15:0]       bytes_seen_ff, bytes_seen_in;
   logic [15:0]       total_length_ff, total_length_in;
   logic [7:0]        held_byte_ff, held_byte_in;
   upf_pkg::kind_type kind_seen_ff, kind_seen_in;
   logic [7:0]        name_length_ff, name_length_in;
   logic [7:0]        address_left_ff, address_left_in;
   logic [15:0]       port_held_ff, port_held_in;
   logic              discarding_ff, discarding_in;

   logic [15:0]          bseen;
   logic [15:0]          word;
   logic [15:0]          rem_type;
   logic [15:0]          rem_dlen;
   logic [7:0]           addr_dec;
   logic [15:0]          port_now;
   logic                 clear_frame;
   upf_pkg::class_type   cls;
   upf_pkg::status_type  st;

   always_comb begin
      phase_in        = phase_ff;
      bytes_seen_in   = bytes_seen_ff;
      total_length_in = total_length_ff;
      held_byte_in    = held_byte_ff;
      kind_seen_in    = kind_seen_ff;
      name_length_in  = name_length_ff;
      address_left_in = address_left_ff;
      port_held_in    = port_held_ff;
      discarding_in   = discarding_ff;

      bseen     = bytes_seen_ff + 16'd1;
      word      = {held_byte_ff, data_byte};
      // room after the type byte, and after the name length byte
      rem_type  = total_length_ff - MIN_LENGTH;
      rem_dlen  = rem_type - 16'd1;
      addr_dec  = address_left_ff - 8'd1;
      port_now  = port_held_ff;
      clear_frame = 1'b0;
      cls       = upf_pkg::CLS_HEADER;
      st        = upf_pkg::ST_BUSY;

      if (discarding_ff) begin
         cls = upf_pkg::CLS_DISCARD;
         if (end_of_data) begin
            discarding_in = 1'b0;
            clear_frame   = 1'b1;
         end
      end else begin
         bytes_seen_in = bseen;
         case (phase_ff)
            PH_MAGIC_LO: begin
               if (word != cfg.magic) st = upf_pkg::ST_BAD_MAGIC;
               else phase_in = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               held_byte_in = data_byte;
               phase_in     = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               total_length_in = word;
               if (word < MIN_LENGTH) st = upf_pkg::ST_BAD_LENGTH;
               else if (bseen >= HDR_LEN) phase_in = PH_TYPE;
               else phase_in = PH_HDR_REST;
            end
            PH_HDR_REST: begin
               if (bseen >= HDR_LEN) phase_in = PH_TYPE;
            end
            PH_TYPE: begin
               // register order decides when codes collide
               if (data_byte == cfg.ipv4_code) begin
                  kind_seen_in = upf_pkg::KIND_IPV4;
                  if (rem_type < upf_pkg::IPV4_ADDR_BYTES + upf_pkg::PORT_BYTES) begin
                     st = upf_pkg::ST_OVERRUN;
                  end else begin
                     address_left_in = upf_pkg::IPV4_ADDR_BYTES[7:0];
                     phase_in        = PH_ADDR;
                  end
               end else if (data_byte == cfg.domain_code) begin
                  kind_seen_in = upf_pkg::KIND_DOMAIN;
                  if (rem_type == 16'd0) st = upf_pkg::ST_OVERRUN;
                  else phase_in = PH_DLEN;
               end else if (data_byte == cfg.ipv6_code) begin
                  kind_seen_in = upf_pkg::KIND_IPV6;
                  if (rem_type < upf_pkg::IPV6_ADDR_BYTES + upf_pkg::PORT_BYTES) begin
                     st = upf_pkg::ST_OVERRUN;
                  end else begin
                     address_left_in = upf_pkg::IPV6_ADDR_BYTES[7:0];
                     phase_in        = PH_ADDR;
                  end
               end else begin
                  st = upf_pkg::ST_BAD_TYPE;
               end
            end
            PH_DLEN: begin
               cls            = upf_pkg::CLS_ADDRESS;
               name_length_in = data_byte;
               if ({1'b0, rem_dlen} < 17'(data_byte) + 17'(upf_pkg::PORT_BYTES)) begin
                  st = upf_pkg::ST_OVERRUN;
               end else begin
                  address_left_in = data_byte;
                  phase_in = (data_byte != 8'd0) ? PH_ADDR : PH_PORT_HI;
               end
            end
            PH_ADDR: begin
               cls             = upf_pkg::CLS_ADDRESS;
               address_left_in = addr_dec;
               if (addr_dec == 8'd0) phase_in = PH_PORT_HI;
            end
            PH_PORT_HI: begin
               cls          = upf_pkg::CLS_ADDRESS;
               held_byte_in = data_byte;
               phase_in     = PH_PORT_LO;
            end
            PH_PORT_LO: begin
               cls          = upf_pkg::CLS_ADDRESS;
               port_held_in = word;
               port_now     = word;
               if (bseen >= total_length_ff) st = upf_pkg::ST_OK;
               else phase_in = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               cls = upf_pkg::CLS_PAYLOAD;
               if (bseen >= total_length_ff) st = upf_pkg::ST_OK;
            end
            default: begin
               // first magic byte, also any unused phase code
               held_byte_in = data_byte;
               phase_in     = PH_MAGIC_LO;
            end
         endcase
         if (st == upf_pkg::ST_BUSY && end_of_data) st = upf_pkg::ST_TRUNCATED;
         if (st != upf_pkg::ST_BUSY) begin
            clear_frame = 1'b1;
            if (st != upf_pkg::ST_OK && !end_of_data) discarding_in = 1'b1;
         end
      end

      result               = '0;
      result.byte_out      = data_byte;
      result.byte_class    = cls;
      result.frame_done    = (st != upf_pkg::ST_BUSY);
      result.status        = st;
      result.address_kind  = upf_pkg::KIND_IPV4;
      if (st == upf_pkg::ST_OK) begin
         result.address_kind = kind_seen_ff;
         result.port_number  = port_now;
         result.frame_length = total_length_ff;
         result.domain_length =
            (kind_seen_ff == upf_pkg::KIND_DOMAIN) ? name_length_ff : 8'd0;
      end

      if (clear_frame) begin
         phase_in        = PH_MAGIC_HI;
         bytes_seen_in   = '0;
         total_length_in = '0;
         held_byte_in    = '0;
         kind_seen_in    = upf_pkg::KIND_IPV4;
         name_length_in  = '0;
         address_left_in = '0;
         port_held_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_MAGIC_HI;
         bytes_seen_ff   <= '0;
         total_length_ff <= '0;
         held_byte_ff    <= '0;
         kind_seen_ff    <= upf_pkg::KIND_IPV4;
         name_length_ff  <= '0;
         address_left_ff <= '0;
         port_held_ff    <= '0;
         discarding_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         bytes_seen_ff   <= bytes_seen_in;
         total_length_ff <= total_length_in;
         held_byte_ff    <= held_byte_in;
         kind_seen_ff    <= kind_seen_in;
         name_length_ff  <= name_length_in;
         address_left_ff <= address_left_in;
         port_held_ff    <= port_held_in;
         discarding_ff   <= discarding_in;
      end
   end

endmodule

>>> src/upf_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upf_fifo: two-entry result queue
// decouples the parser from the output stage
// ----------------------------------------------------------------------------
module upf_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  upf_pkg::result_type push_data,
   output logic                push_ready,
   input  logic                pop,
   output logic                pop_valid,
   output upf_pkg::result_type pop_data
);

   upf_pkg::result_type entry_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/upf_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upf_out: output register of the result channel
// pulls from the queue whenever the register is empty or being drained
// ----------------------------------------------------------------------------
module upf_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  upf_pkg::result_type in_data,
   output logic                in_pop,
   output logic                out_valid,
   output upf_pkg::result_type out_data,
   input  logic                out_ready
);

   logic                valid_ff, valid_in;
   upf_pkg::result_type data_ff;

   assign in_pop    = in_valid && (!valid_ff || out_ready);
   assign valid_in  = in_pop || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_pop) begin
         data_ff <= in_data;
      end
   end

endmodule

>>> src/proxy_udp_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proxy_udp_frame_parser: streaming checker for proxy udp frames
// tags every byte of a socks5-style address frame and reports frame status
// ----------------------------------------------------------------------------
// usage
//   req channel: one stream byte per transaction, req_tlast marks the last
//   byte currently available; rsp channel: exactly one result per byte, in
//   order, rsp_tlast set on the result that ends a frame (good or bad)
//   csr port: magic word and the three address-type codes; the user writes them only
//   while idle (the block has no check); pready is always high, reads return the value
// throughput and pipeline
//   one byte per clock sustained while the queue has room (rsp_tready keeps up);
//   each result passes two register stages: the queue entry, then the output register
//   the per-byte parse step is combinational compares and subtracts on 16/17-bit values
// reset
//   synchronous, active high; parser goes back to the first magic byte,
//   queue and output register empty, csrs take their default codes
// stall
//   the two-entry queue absorbs a stalled receiver; req_tready drops only
//   when the queue is full, so no result is lost or repeated
// ----------------------------------------------------------------------------
module proxy_udp_frame_parser #(
   parameter int HEADER_BYTES = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   // request stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // data_byte
   input  logic                           req_tlast,   // end_of_data
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // byte_out[7:0], status[10:8], port_number[26:11], frame_length[42:27],
   // domain_length[50:43], zero fill[55:51]
   output logic [55:0]                    rsp_tdata,
   output logic [3:0]                     rsp_tuser,   // byte_class[1:0], address_kind[3:2]
   output logic                           rsp_tlast,   // frame_done
   // csr port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [upf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [upf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [upf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   upf_pkg::cfg_type    cfg_ff, cfg_in;
   logic                csr_wr;
   logic [1:0]          csr_index;
   logic                req_fire;
   upf_pkg::result_type parse_result;
   logic                q_valid;
   logic                q_pop;
   upf_pkg::result_type q_data;
   upf_pkg::result_type rsp_result;

   // ---------------- csr block ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_index)
            upf_pkg::REG_MAGIC:       cfg_in.magic       = csr_pwdata[15:0];
            upf_pkg::REG_IPV4_CODE:   cfg_in.ipv4_code   = csr_pwdata[7:0];
            upf_pkg::REG_DOMAIN_CODE: cfg_in.domain_code = csr_pwdata[7:0];
            upf_pkg::REG_IPV6_CODE:   cfg_in.ipv6_code   = csr_pwdata[7:0];
            default:                  cfg_in             = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         upf_pkg::REG_MAGIC:       csr_prdata = {16'd0, cfg_ff.magic};
         upf_pkg::REG_IPV4_CODE:   csr_prdata = {24'd0, cfg_ff.ipv4_code};
         upf_pkg::REG_DOMAIN_CODE: csr_prdata = {24'd0, cfg_ff.domain_code};
         upf_pkg::REG_IPV6_CODE:   csr_prdata = {24'd0, cfg_ff.ipv6_code};
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic       <= 16'd0;
         cfg_ff.ipv4_code   <= 8'd1;
         cfg_ff.domain_code <= 8'd3;
         cfg_ff.ipv6_code   <= 8'd4;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- front: parse and classify ----------------
   assign req_fire = req_tvalid && req_tready;

   upf_parser #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .accept      (req_fire),
      .data_byte   (req_tdata),
      .end_of_data (req_tlast),
      .result      (parse_result)
   );

   // ---------------- queue between front and back ----------------
   upf_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (req_fire),
      .push_data  (parse_result),
      .push_ready (req_tready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_data)
   );

   // ---------------- back: output register ----------------
   upf_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_data   (q_data),
      .in_pop    (q_pop),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_result),
      .out_ready (rsp_tready)
   );

   // result transaction packing, highest field first
   assign rsp_tdata = {5'd0,
                       rsp_result.domain_length,
                       rsp_result.frame_length,
                       rsp_result.port_number,
                       rsp_result.status,
                       rsp_result.byte_out};
   assign rsp_tuser = {rsp_result.address_kind, rsp_result.byte_class};
   assign rsp_tlast = rsp_result.frame_done;

endmodule

>>> src/upf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upf_checker: port-level checks of the frame parser
// watches the result stream only
// ----------------------------------------------------------------------------
module upf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [3:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic [2:0] status;
   logic [1:0] byte_class;

   assign status     = rsp_tdata[10:8];
   assign byte_class = rsp_tuser[1:0];

   // stalled transaction holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // frame end exactly when a status is reported
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (status != upf_pkg::ST_BUSY)))
      else $error("frame_done does not match status");

   // frame info only on a good frame end
   a_info: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status != upf_pkg::ST_OK) |->
         (rsp_tdata[50:11] == 40'd0) && (rsp_tuser[3:2] == 2'd0))
      else $error("frame info on a result that is not ok");

   // discarded bytes never carry a status, and the fill bits stay zero
   a_discard: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (byte_class == upf_pkg::CLS_DISCARD) |->
         (status == upf_pkg::ST_BUSY) && (rsp_tdata[55:51] == 5'd0))
      else $error("discarded byte with a status");

endmodule

bind proxy_udp_frame_parser upf_checker u_upf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
